// ===== hdl/nsos_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nsos_pkg;

    // field widths
    localparam int TS_W       = 32;
    localparam int RTT_W      = 34;
    localparam int OFS_W      = 32;
    localparam int RSSI_W     = 8;
    localparam int CHAN_W     = 4;
    localparam int QUAL_W     = 2;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // stream word widths
    localparam int IN_W       = 144;
    localparam int OUT_W      = 80;
    localparam int OUT_USER_W = 1;

    // quality codes
    localparam logic [QUAL_W-1:0] QUAL_SYNC        = 2'd0;
    localparam logic [QUAL_W-1:0] QUAL_NO_RX_STAMP = 2'd1;
    localparam logic [QUAL_W-1:0] QUAL_POWER_SAVE  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 1'd1;

    localparam logic [TS_W-1:0]  TIMEOUT_RESET = 32'd100000;
    localparam logic [CNT_W-1:0] LIMIT_RESET   = 8'd8;

    // classified sample handed from front to back
    typedef struct packed {
        logic signed [RTT_W-1:0] rtt;
        logic [OFS_W-1:0]        offset;
        logic [RSSI_W-1:0]       rssi;
        logic [CHAN_W-1:0]       chan;
        logic [QUAL_W-1:0]       quality;
        logic                    last;
    } nsos_entry_t;

    typedef struct packed {
        logic [TS_W-1:0]  timeout;
        logic [CNT_W-1:0] limit;
    } nsos_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/nsos_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsos_front
    import nsos_pkg::*;
(
    input  wire logic [IN_W-1:0] data,
    input  wire logic            last,
    output nsos_entry_t          entry
);

    logic [TS_W-1:0]    t1, t2, t3, t4;
    logic [TS_W-1:0]    d21, d34, d41, d32;
    logic               lps, rps, rok, lok;
    logic [TS_W:0]      sum;
    logic [TS_W:0]      sum_adj;
    logic [RTT_W-1:0]   rtt;

    assign t1  = data[31:0];
    assign t2  = data[63:32];
    assign t3  = data[95:64];
    assign t4  = data[127:96];
    assign lps = data[140];
    assign rps = data[141];
    assign rok = data[142];
    assign lok = data[143];

    // wrap differences, read as signed
    assign d21 = t2 - t1;
    assign d34 = t3 - t4;
    assign d41 = t4 - t1;
    assign d32 = t3 - t2;

    assign rtt = {{2{d41[TS_W-1]}}, d41} - {{2{d32[TS_W-1]}}, d32};

    // halve toward zero: bias negative sums by one before the shift
    assign sum     = {d21[TS_W-1], d21} + {d34[TS_W-1], d34};
    assign sum_adj = sum + {{TS_W{1'b0}}, sum[TS_W]};

    always_comb
    begin
        entry.rtt    = rtt;
        entry.offset = sum_adj[TS_W:1];
        entry.rssi   = data[135:128];
        entry.chan   = data[139:136];
        entry.last   = last;
        if (!rok || !lok)
        begin
            entry.quality = QUAL_NO_RX_STAMP;
        end
        else if (lps || rps)
        begin
            entry.quality = QUAL_POWER_SAVE;
        end
        else
        begin
            entry.quality = QUAL_SYNC;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nsos_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsos_queue
    import nsos_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire nsos_entry_t push_entry,
    output logic             full,
    input  wire logic        pop,
    output logic             not_empty,
    output nsos_entry_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    nsos_entry_t       mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nsos_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsos_back
    import nsos_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nsos_cfg_t          cfg,
    input  wire logic               q_valid,
    input  wire nsos_entry_t        q_entry,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [OUT_W-1:0]        m_tdata,
    output logic [OUT_USER_W-1:0]   m_tuser
);

    logic                  best_valid_reg, best_valid_next;
    logic [OFS_W-1:0]      best_offset_reg, best_offset_next;
    logic [TS_W-1:0]       best_rt_reg, best_rt_next;
    logic [RSSI_W-1:0]     best_rssi_reg, best_rssi_next;
    logic [CHAN_W-1:0]     best_chan_reg, best_chan_next;
    logic [QUAL_W-1:0]     best_qual_reg, best_qual_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;

    logic            out_free, in_range, cand, upd;
    logic [TS_W-1:0] rtt32;
    logic            sel_valid;
    logic [OFS_W-1:0]  sel_offset;
    logic [TS_W-1:0]   sel_rt;
    logic [RSSI_W-1:0] sel_rssi;
    logic [CHAN_W-1:0] sel_chan;
    logic [QUAL_W-1:0] sel_qual;

    assign out_free = !out_valid_reg || m_tready;
    // a last sample waits until the output register can take its result
    assign q_pop    = q_valid && (!q_entry.last || out_free);

    assign rtt32    = q_entry.rtt[TS_W-1:0];
    assign in_range = !q_entry.rtt[RTT_W-1] && (q_entry.rtt[RTT_W-2:TS_W] == '0)
                      && (rtt32 <= cfg.timeout);
    assign cand     = in_range && (count_reg < cfg.limit);
    // strict compare keeps the earliest of equal round trips
    assign upd      = cand && (!best_valid_reg || (rtt32 < best_rt_reg));

    assign sel_valid  = best_valid_reg || upd;
    assign sel_offset = upd ? q_entry.offset  : best_offset_reg;
    assign sel_rt     = upd ? rtt32           : best_rt_reg;
    assign sel_rssi   = upd ? q_entry.rssi    : best_rssi_reg;
    assign sel_chan   = upd ? q_entry.chan    : best_chan_reg;
    assign sel_qual   = upd ? q_entry.quality : best_qual_reg;

    always_comb
    begin
        best_valid_next  = best_valid_reg;
        best_offset_next = best_offset_reg;
        best_rt_next     = best_rt_reg;
        best_rssi_next   = best_rssi_reg;
        best_chan_next   = best_chan_reg;
        best_qual_next   = best_qual_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            if (q_entry.last)
            begin
                // emit, then start a fresh run
                out_valid_next   = 1'b1;
                out_data_next    = {2'b00, sel_qual, sel_chan, sel_rssi, sel_rt, sel_offset};
                out_user_next    = OUT_USER_W'(sel_valid);
                best_valid_next  = 1'b0;
                best_offset_next = '0;
                best_rt_next     = '0;
                best_rssi_next   = '0;
                best_chan_next   = '0;
                best_qual_next   = '0;
                count_next       = '0;
            end
            else
            begin
                best_valid_next  = sel_valid;
                best_offset_next = sel_offset;
                best_rt_next     = sel_rt;
                best_rssi_next   = sel_rssi;
                best_chan_next   = sel_chan;
                best_qual_next   = sel_qual;
                if (cand)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg  <= 1'b0;
            best_offset_reg <= '0;
            best_rt_reg     <= '0;
            best_rssi_reg   <= '0;
            best_chan_reg   <= '0;
            best_qual_reg   <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            best_valid_reg  <= best_valid_next;
            best_offset_reg <= best_offset_next;
            best_rt_reg     <= best_rt_next;
            best_rssi_reg   <= best_rssi_next;
            best_chan_reg   <= best_chan_next;
            best_qual_reg   <= best_qual_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

// ===== hdl/ntp_sample_offset_select.sv =====
// a last word passes from the queue to the output register, which drives m_tvalid
// throughput: one word per cycle unless stalled; the front classifies in the accept cycle,
//   the queue decouples it from the selection stage, which retires one word per unstalled cycle
// a last word stalls only while the output register holds an untaken result
// reset: rst_n asynchronous active low clears queue, running best, count and output valid;
//   registers return to timeout 100000 us and limit 8
`timescale 1ns / 1ps
`default_nettype none

module ntp_sample_offset_select
    import nsos_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // t1_us, t2_us, t3_us, t4_us, rssi, radio_channel, local_power_save,
    // remote_power_save, remote_rx_stamp_ok, local_rx_stamp_ok
    input  wire logic [IN_W-1:0]       s_tdata,
    // last_sample
    input  wire logic                  s_tlast,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // offset_us, round_trip_us, sel_rssi, sel_channel, quality, 2 bits zero fill
    output logic [OUT_W-1:0]           m_tdata,
    // found
    output logic [OUT_USER_W-1:0]      m_tuser,
    // register write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [TS_W-1:0]  timeout_reg, timeout_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    nsos_cfg_t        cfg;

    always_comb
    begin
        timeout_next = timeout_reg;
        limit_next   = limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_next = cfg_data[TS_W-1:0];
                CFG_LIMIT:   limit_next   = cfg_data[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
            limit_reg   <= limit_next;
        end
    end

    assign cfg.timeout = timeout_reg;
    assign cfg.limit   = limit_reg;

    // front: wrap differences, round trip, halved offset, quality code
    nsos_entry_t front_entry;
    nsos_entry_t head_entry;
    logic        q_full, q_valid, q_pop;

    nsos_front u_front
    (
        .data  (s_tdata),
        .last  (s_tlast),
        .entry (front_entry)
    );

    // short queue between classification and selection
    assign s_tready = !q_full;

    nsos_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (head_entry)
    );

    // back: range and limit check, running minimum, result register
    nsos_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hdl/nsos_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsos_checker
    import nsos_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_W-1:0]      m_tdata,
    input wire logic [OUT_USER_W-1:0] m_tuser
);

    // reset seen at an edge leaves no result behind
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // not found carries all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("not-found result has nonzero fields");

    // quality is one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[77:76] != 2'b11)
        else $error("undefined quality code");

endmodule

bind ntp_sample_offset_select nsos_checker u_nsos_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
